// ----- hw/rtl/pooled_linked_list_manager_top_defines.svh -----
// assertion macros used by the pooled list manager controller
// depends on nothing
`ifndef POOLED_LINKED_LIST_MANAGER_TOP_DEFINES_SVH
`define POOLED_LINKED_LIST_MANAGER_TOP_DEFINES_SVH

// implication checked at every clock edge outside reset
`define PLM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define PLM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/plm_pkg.sv -----
// package for the pooled list manager: sizes, codes, command and status types
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package plm_pkg;
   localparam int ENTRIES = 128;
   localparam int BUCKETS = 256;
   localparam int EW = $clog2(ENTRIES);
   localparam int LW = $clog2(ENTRIES + 1);
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam logic [LW-1:0] NIL = LW'(ENTRIES);

   localparam logic [1:0] MODE_CREATE = 2'd0;
   localparam logic [1:0] MODE_KILL   = 2'd1;
   localparam logic [1:0] MODE_MOVE   = 2'd2;
   localparam logic [1:0] MODE_QUERY  = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_UNUSED = 2'd2;

   // datapath operations
   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_LATCH     = 4'd1;  // capture request, read entry_bucket
   localparam logic [3:0] OP_RD_BL     = 4'd2;  // read bucket_link[free_head]
   localparam logic [3:0] OP_CREATE    = 4'd3;  // commit create
   localparam logic [3:0] OP_BH_RD     = 4'd4;  // read bucket_head[old]
   localparam logic [3:0] OP_ACT_START = 4'd5;  // cur = active_head, read link
   localparam logic [3:0] OP_ACT_STEP  = 4'd6;  // advance active walk
   localparam logic [3:0] OP_BKT_START = 4'd7;  // cur = bucket head, read link
   localparam logic [3:0] OP_BKT_STEP  = 4'd8;  // advance bucket walk
   localparam logic [3:0] OP_RD_E_A    = 4'd9;  // read active_link[e]
   localparam logic [3:0] OP_RD_E_B    = 4'd10; // read bucket_link[e]
   localparam logic [3:0] OP_FIX_A     = 4'd11; // splice active list
   localparam logic [3:0] OP_FIX_B     = 4'd12; // splice bucket list
   localparam logic [3:0] OP_KILL_FIN  = 4'd13;
   localparam logic [3:0] OP_MOVE_RD   = 4'd14; // read bucket_head[new]
   localparam logic [3:0] OP_MOVE_FIN  = 4'd15;

   typedef struct packed {
      logic [3:0] op;
   } plm_cmd_type;

   typedef struct packed {
      logic       pool_empty;
      logic       unused;
      logic [1:0] mode;
      logic       head_hit;   // cur equals entry
      logic       link_hit;   // link of cur equals entry
      logic       walk_end;   // cur is none or step bound reached
   } plm_sts_type;
endpackage
`default_nettype wire

// ----- hw/rtl/pooled_linked_list_manager_top.sv -----
// channel    | ports                                                     | direction
// req        | req_valid req_stall req_mode req_entry req_bucket         | in
// rsp        | rsp_valid rsp_stall rsp_new_entry rsp_position rsp_status | out
// one word in flight; a create or an error answers without a list walk, a query walks
// the active list, a move walks the bucket list and a kill walks the active list and then
// the bucket list, one link per cycle; rsp_valid rises once the operation is done
// after reset the bucket link ram is filled while requests are stalled
// the result word holds while rsp_stall is high; the next request can be taken in the cycle after the result is taken
// depends on plm_pkg, plm_ctrl, plm_datapath
`timescale 1ns / 1ps
`default_nettype none
module pooled_linked_list_manager_top import plm_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_mode,
   input  wire logic [6:0] req_entry,
   input  wire logic [7:0] req_bucket,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [6:0]      rsp_new_entry,
   output logic [6:0]      rsp_position,
   output logic [1:0]      rsp_status
);
   plm_cmd_type cmd;
   plm_sts_type sts;
   logic init_we;
   logic [EW:0] init_cnt;

   plm_ctrl u_ctrl (.clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .cmd, .init_we, .init_cnt);
   plm_datapath u_dp (.clock, .reset, .cmd, .init_we, .init_cnt, .req_mode, .req_entry,
      .req_bucket, .sts, .rsp_new_entry, .rsp_position, .rsp_status);
endmodule
`default_nettype wire

// ----- hw/rtl/plm_ram.sv -----
// generic simple dual-port ram, one write and one registered read per cycle
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
module plm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/plm_datapath.sv -----
// datapath: link memories, list heads, walk pointer and result registers
// depends on plm_pkg and plm_ram
`timescale 1ns / 1ps
`default_nettype none
module plm_datapath import plm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire plm_cmd_type cmd,
   input  wire logic        init_we,
   input  wire logic [EW:0] init_cnt,
   input  wire logic [1:0]  req_mode,
   input  wire logic [6:0]  req_entry,
   input  wire logic [7:0]  req_bucket,
   output plm_sts_type      sts,
   output logic [6:0]       rsp_new_entry,
   output logic [6:0]       rsp_position,
   output logic [1:0]       rsp_status
);
   logic [1:0] mode_ff;
   logic [EW-1:0] ent_ff;
   logic ent_ok_ff;
   logic [BW-1:0] bkt_ff, old_ff;
   logic [LW-1:0] free_ff, act_head_ff, cur_ff;
   logic [EW:0] steps_ff;
   logic [ENTRIES-1:0] used_ff;
   logic [BUCKETS-1:0] bh_valid_ff;
   logic [6:0] new_ff, pos_ff;
   logic [1:0] st_ff;
   logic [BW-1:0] bh_ra_ff;
   logic walk_act_ff;

   // memories
   logic bl_we, al_we, eb_we, bh_we;
   logic [EW-1:0] bl_wa, bl_ra, al_wa, al_ra, eb_wa, eb_ra;
   logic [LW-1:0] bl_wd, al_wd, bl_rd, al_rd, bh_wd, bh_rd;
   logic [BW-1:0] eb_rd, bh_wa, bh_ra;

   plm_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_bl (.clock, .we(bl_we), .waddr(bl_wa),
      .wdata(bl_wd), .raddr(bl_ra), .rdata(bl_rd));
   plm_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_al (.clock, .we(al_we), .waddr(al_wa),
      .wdata(al_wd), .raddr(al_ra), .rdata(al_rd));
   plm_ram #(.WIDTH(BW), .DEPTH(ENTRIES)) u_eb (.clock, .we(eb_we), .waddr(eb_wa),
      .wdata(bkt_ff), .raddr(eb_ra), .rdata(eb_rd));
   plm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_bh (.clock, .we(bh_we), .waddr(bh_wa),
      .wdata(bh_wd), .raddr(bh_ra), .rdata(bh_rd));

   logic [LW-1:0] bh_val;
   logic [EW-1:0] ent_in;
   logic ent_ok_in;
   logic [LW-1:0] ent_ext;
   logic [LW-1:0] link_rd;
   logic [LW-1:0] init_next;
   logic [BW-1:0] old_in;

   assign ent_in = EW'(req_entry);
   assign ent_ok_in = ({{(LW > 7 ? LW - 7 : 1){1'b0}}, req_entry} < (LW > 7 ? LW : 8)'(ENTRIES));
   assign ent_ext = {1'b0, ent_ff};
   assign bh_val = bh_valid_ff[bh_ra_ff] ? bh_rd : NIL;
   assign init_next = LW'(init_cnt) + LW'(1);
   assign link_rd = walk_act_ff ? al_rd : bl_rd;
   assign old_in = eb_rd;

   always_comb begin
      bl_we = 1'b0; bl_wa = ent_ff; bl_wd = NIL; bl_ra = ent_ff;
      al_we = 1'b0; al_wa = ent_ff; al_wd = act_head_ff; al_ra = ent_ff;
      eb_we = 1'b0; eb_wa = ent_ff; eb_ra = ent_ff;
      bh_we = 1'b0; bh_wa = bkt_ff; bh_wd = ent_ext; bh_ra = bkt_ff;
      if (init_we) begin
         bl_we = 1'b1;
         bl_wa = EW'(init_cnt);
         bl_wd = (init_next >= NIL) ? NIL : init_next;
      end
      unique case (cmd.op)
         OP_LATCH: begin
            eb_ra = ent_in;
            bh_ra = BW'(req_bucket);
         end
         OP_RD_BL: begin
            bl_ra = EW'(free_ff);
            bh_ra = bkt_ff;
         end
         OP_CREATE: begin
            bl_we = 1'b1; bl_wa = EW'(free_ff); bl_wd = bh_val;
            al_we = 1'b1; al_wa = EW'(free_ff); al_wd = act_head_ff;
            eb_we = 1'b1; eb_wa = EW'(free_ff);
            bh_we = 1'b1; bh_wa = bkt_ff; bh_wd = free_ff;
         end
         OP_BH_RD: bh_ra = old_ff;
         OP_ACT_START: al_ra = EW'(act_head_ff);
         OP_ACT_STEP: al_ra = EW'(al_rd);
         OP_BKT_START: begin
            bl_ra = EW'(bh_val);
            bh_ra = old_ff;
         end
         OP_BKT_STEP: begin
            bl_ra = EW'(bl_rd);
            bh_ra = old_ff;
         end
         OP_RD_E_A: al_ra = ent_ff;
         OP_RD_E_B: begin
            bl_ra = ent_ff;
            bh_ra = old_ff;
         end
         OP_FIX_A: begin
            if (cur_ff != ent_ext && cur_ff < NIL) begin
               al_we = 1'b1; al_wa = EW'(cur_ff); al_wd = al_rd;
            end
            al_ra = ent_ff;
         end
         OP_FIX_B: begin
            bh_ra = old_ff;
            if (cur_ff == ent_ext) begin
               bh_we = 1'b1; bh_wa = old_ff; bh_wd = bl_rd;
            end else if (cur_ff < NIL) begin
               bl_we = 1'b1; bl_wa = EW'(cur_ff); bl_wd = bl_rd;
            end
         end
         OP_KILL_FIN: begin
            bl_we = 1'b1; bl_wa = ent_ff; bl_wd = free_ff;
         end
         OP_MOVE_RD: bh_ra = bkt_ff;
         OP_MOVE_FIN: begin
            eb_we = 1'b1;
            bl_we = 1'b1; bl_wa = ent_ff; bl_wd = bh_val;
            bh_we = 1'b1; bh_wa = bkt_ff; bh_wd = ent_ext;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '0;
         act_head_ff <= NIL;
         used_ff <= '0;
         bh_valid_ff <= '0;
      end else begin
         unique case (cmd.op)
            OP_CREATE: begin
               free_ff <= bl_rd;
               act_head_ff <= free_ff;
               used_ff[EW'(free_ff)] <= 1'b1;
               bh_valid_ff[bkt_ff] <= 1'b1;
            end
            OP_FIX_A: if (cur_ff == ent_ext) act_head_ff <= al_rd;
            OP_FIX_B: if (cur_ff == ent_ext) bh_valid_ff[old_ff] <= 1'b1;
            OP_KILL_FIN: begin
               free_ff <= ent_ext;
               used_ff[ent_ff] <= 1'b0;
            end
            OP_MOVE_FIN: bh_valid_ff[bkt_ff] <= 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      bh_ra_ff <= bh_ra;
      unique case (cmd.op)
         OP_LATCH: begin
            mode_ff <= req_mode;
            ent_ff <= ent_in;
            ent_ok_ff <= ent_ok_in;
            bkt_ff <= BW'(req_bucket);
            new_ff <= '0;
            pos_ff <= '0;
            st_ff <= ST_OK;
         end
         OP_RD_BL: begin
            old_ff <= old_in;
            if (mode_ff == MODE_CREATE) begin
               if (free_ff >= NIL) st_ff <= ST_EMPTY;
               else new_ff <= 7'(free_ff);
            end else if (!(ent_ok_ff && used_ff[ent_ff])) begin
               st_ff <= ST_UNUSED;
            end
         end
         OP_ACT_START: begin
            cur_ff <= act_head_ff;
            steps_ff <= '0;
            walk_act_ff <= 1'b1;
         end
         OP_ACT_STEP: begin
            cur_ff <= al_rd;
            steps_ff <= steps_ff + (EW + 1)'(1);
         end
         OP_BKT_START: begin
            cur_ff <= bh_val;
            steps_ff <= '0;
            walk_act_ff <= 1'b0;
         end
         OP_BKT_STEP: begin
            cur_ff <= bl_rd;
            steps_ff <= steps_ff + (EW + 1)'(1);
         end
         OP_RD_E_A: begin
            walk_act_ff <= 1'b1;
            // walk stops on the entry itself or on its predecessor
            if (mode_ff == MODE_QUERY) begin
               if (cur_ff == ent_ext) pos_ff <= 7'(steps_ff);
               else if (cur_ff < NIL) pos_ff <= 7'(steps_ff + (EW + 1)'(1));
            end
         end
         OP_RD_E_B: walk_act_ff <= 1'b0;
         default: ;
      endcase
   end

   // status toward the controller
   always_comb begin
      sts.pool_empty = free_ff >= NIL;
      sts.unused = !(ent_ok_ff && used_ff[ent_ff]);
      sts.mode = mode_ff;
      sts.head_hit = cur_ff == ent_ext;
      sts.link_hit = link_rd == ent_ext;
      sts.walk_end = cur_ff >= NIL || steps_ff >= (EW + 1)'(ENTRIES);
   end

   assign rsp_new_entry = new_ff;
   assign rsp_position = pos_ff;
   assign rsp_status = st_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/plm_ctrl.sv -----
// controller: sequences create, kill, move and query over the datapath
// depends on plm_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "pooled_linked_list_manager_top_defines.svh"
module plm_ctrl import plm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   input  wire plm_sts_type sts,
   output plm_cmd_type      cmd,
   output logic             init_we,
   output logic [EW:0]      init_cnt
);
   localparam logic [4:0] S_INIT   = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_DEC    = 5'd2;
   localparam logic [4:0] S_CRT    = 5'd3;
   localparam logic [4:0] S_AWALK  = 5'd4;
   localparam logic [4:0] S_AFIX   = 5'd5;
   localparam logic [4:0] S_BHEAD  = 5'd6;
   localparam logic [4:0] S_BSTART = 5'd7;
   localparam logic [4:0] S_BWALK  = 5'd8;
   localparam logic [4:0] S_BFIX   = 5'd9;
   localparam logic [4:0] S_TAIL   = 5'd10;
   localparam logic [4:0] S_MRD    = 5'd11;
   localparam logic [4:0] S_RSP    = 5'd12;
   localparam logic [4:0] S_ASTART = 5'd13;
   localparam logic [4:0] S_ARDE   = 5'd14;
   localparam logic [4:0] S_BRDE   = 5'd15;
   localparam logic [4:0] S_MFIN   = 5'd16;

   logic [4:0] state_ff, state_in;
   logic [EW:0] cnt_ff, cnt_in;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_RSP;
   assign init_we = state_ff == S_INIT;
   assign init_cnt = cnt_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd.op = OP_NONE;
      unique case (state_ff)
         S_INIT: begin
            cnt_in = cnt_ff + (EW + 1)'(1);
            if (cnt_ff == (EW + 1)'(ENTRIES - 1)) state_in = S_IDLE;
         end
         S_IDLE: if (req_valid) begin
            cmd.op = OP_LATCH;
            state_in = S_DEC;
         end
         S_DEC: begin
            cmd.op = OP_RD_BL;
            if (sts.mode == MODE_CREATE) state_in = sts.pool_empty ? S_RSP : S_CRT;
            else if (sts.unused) state_in = S_RSP;
            else if (sts.mode == MODE_MOVE) state_in = S_BHEAD;
            else state_in = S_ASTART;
         end
         S_CRT: begin
            cmd.op = OP_CREATE;
            state_in = S_RSP;
         end
         S_ASTART: begin
            cmd.op = OP_ACT_START;
            state_in = S_AWALK;
         end
         S_AWALK: begin
            // cur held, link of cur on the read port
            if (sts.walk_end || sts.head_hit || sts.link_hit) begin
               state_in = S_ARDE;
            end else begin
               cmd.op = OP_ACT_STEP;
            end
         end
         S_ARDE: begin
            cmd.op = OP_RD_E_A;
            state_in = (sts.mode == MODE_QUERY) ? S_RSP : S_AFIX;
         end
         S_AFIX: begin
            cmd.op = OP_FIX_A;
            state_in = S_BHEAD;
         end
         S_BHEAD: begin
            cmd.op = OP_BH_RD;
            state_in = S_BSTART;
         end
         S_BSTART: begin
            cmd.op = OP_BKT_START;
            state_in = S_BWALK;
         end
         S_BWALK: begin
            if (sts.walk_end || sts.head_hit || sts.link_hit) state_in = S_BRDE;
            else cmd.op = OP_BKT_STEP;
         end
         S_BRDE: begin
            cmd.op = OP_RD_E_B;
            state_in = S_BFIX;
         end
         S_BFIX: begin
            cmd.op = OP_FIX_B;
            state_in = (sts.mode == MODE_KILL) ? S_TAIL : S_MRD;
         end
         S_TAIL: begin
            cmd.op = OP_KILL_FIN;
            state_in = S_RSP;
         end
         S_MRD: begin
            cmd.op = OP_MOVE_RD;
            state_in = S_MFIN;
         end
         S_MFIN: begin
            cmd.op = OP_MOVE_FIN;
            state_in = S_RSP;
         end
         S_RSP: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   `PLM_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != S_IDLE, req_stall, "accept while busy")
   `PLM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "word dropped")
   `PLM_ASSERT_IMP(a_init_quiet, clock, reset, init_we, !rsp_valid && req_stall, "busy during init")
endmodule
`default_nettype wire

// ----- test/tb_pooled_linked_list_manager_top.sv -----
// testbench for pooled_linked_list_manager_top: directed table, pool fill and drain, then random create,
// kill, move and query words, each result checked against an in-bench list model
// depends on plm_pkg and pooled_linked_list_manager_top
`timescale 1ns / 1ps
module tb_pooled_linked_list_manager_top;
   import plm_pkg::*;

   localparam int NDIR = 16;
   localparam int NRAND = 1000;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic [6:0] new_entry;
      logic [6:0] position;
      logic [1:0] status;
   } result_type;

   typedef struct {
      logic [1:0] mode;
      logic [6:0] entry;
      logic [7:0] bucket;
      logic       has_exp;
      result_type res;
   } stim_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [1:0] req_mode;
   logic [6:0] req_entry;
   logic [7:0] req_bucket;
   logic rsp_valid, rsp_stall;
   logic [6:0] rsp_new_entry, rsp_position;
   logic [1:0] rsp_status;

   pooled_linked_list_manager_top DUT (.*);

   // list model state
   int m_blink[ENTRIES];
   int m_alink[ENTRIES];
   int m_ebkt[ENTRIES];
   bit m_used[ENTRIES];
   int m_bhead[BUCKETS];
   int m_free, m_ahead;

   result_type expected_q[$];
   stim_type dir_tab[NDIR];
   int errors;
   int idle_cnt;
   bit quiet;
   int rsp_gap;

   function automatic void pool_reset();
      for (int i = 0; i < ENTRIES; i++) begin
         m_blink[i] = i + 1;
         m_alink[i] = 0;
         m_ebkt[i] = 0;
         m_used[i] = 0;
      end
      for (int b = 0; b < BUCKETS; b++) m_bhead[b] = ENTRIES;
      m_free = 0;
      m_ahead = ENTRIES;
   endfunction

   function automatic void unlink_active(int e);
      int cur;
      cur = m_ahead;
      if (cur == e) begin
         m_ahead = m_alink[e];
         return;
      end
      for (int s = 0; s < ENTRIES && cur < ENTRIES; s++) begin
         if (m_alink[cur] == e) begin
            m_alink[cur] = m_alink[e];
            return;
         end
         cur = m_alink[cur];
      end
   endfunction

   function automatic void unlink_bucket(int b, int e);
      int cur;
      cur = m_bhead[b];
      if (cur == e) begin
         m_bhead[b] = m_blink[e];
         return;
      end
      for (int s = 0; s < ENTRIES && cur < ENTRIES; s++) begin
         if (m_blink[cur] == e) begin
            m_blink[cur] = m_blink[e];
            return;
         end
         cur = m_blink[cur];
      end
   endfunction

   function automatic result_type pool_apply(logic [1:0] mode, logic [6:0] entry,
                                             logic [7:0] bucket);
      result_type r;
      int e, b, old, cur;
      r = '0;
      r.status = ST_OK;
      b = bucket % BUCKETS;
      e = entry;
      if (mode == MODE_CREATE) begin
         if (m_free >= ENTRIES) begin
            r.status = ST_EMPTY;
         end else begin
            e = m_free;
            m_free = m_blink[e];
            m_ebkt[e] = b;
            m_blink[e] = m_bhead[b];
            m_bhead[b] = e;
            m_alink[e] = m_ahead;
            m_ahead = e;
            m_used[e] = 1;
            r.new_entry = e[6:0];
         end
      end else if (e >= ENTRIES || !m_used[e]) begin
         r.status = ST_UNUSED;
      end else begin
         old = m_ebkt[e];
         if (mode == MODE_KILL) begin
            unlink_active(e);
            unlink_bucket(old, e);
            m_blink[e] = m_free;
            m_free = e;
            m_used[e] = 0;
         end else if (mode == MODE_MOVE) begin
            unlink_bucket(old, e);
            m_ebkt[e] = b;
            m_blink[e] = m_bhead[b];
            m_bhead[b] = e;
         end else begin
            cur = m_ahead;
            for (int n = 0; n < ENTRIES && cur < ENTRIES; n++) begin
               if (cur == e) begin
                  r.position = n[6:0];
                  break;
               end
               cur = m_alink[cur];
            end
         end
      end
      return r;
   endfunction

   task automatic report(string what, result_type got, result_type exp);
      errors++;
      $display("mismatch %s: got ne=%0d pos=%0d st=%0d exp ne=%0d pos=%0d st=%0d",
               what, got.new_entry, got.position, got.status,
               exp.new_entry, exp.position, exp.status);
   endtask

   task automatic send(logic [1:0] mode, logic [6:0] entry, logic [7:0] bucket,
                       bit has_exp, result_type res);
      result_type p;
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_entry <= entry;
      req_bucket <= bucket;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = pool_apply(mode, entry, bucket);
      if (has_exp && p != res) report("table", p, res);
      expected_q.push_back(p);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: check and random stall bursts
   always @(posedge clock) begin
      result_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap <= 0;
         idle_cnt <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_new_entry, rsp_position, rsp_status};
            if (expected_q.size() == 0) begin
               report("unexpected", got, '0);
            end else begin
               if (got != expected_q[0]) report("result", got, expected_q[0]);
               void'(expected_q.pop_front());
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cnt <= 0;
         else idle_cnt <= idle_cnt + 1;
         if (quiet) begin
            rsp_stall <= 1'b0;
            rsp_gap <= 0;
         end else if (rsp_gap > 1) begin
            rsp_gap <= rsp_gap - 1;
         end else if (rsp_gap == 1) begin
            rsp_gap <= 0;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 7) == 0) begin
            rsp_gap <= $urandom_range(1, 8);
            rsp_stall <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cnt >= WATCHDOG) begin
         $display("tb_pooled_linked_list_manager_top failed");
         $finish;
      end
   end

   initial begin
      result_type none;
      int n, pick, mode_r;
      none = '0;
      errors = 0;
      quiet = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_CREATE;
      req_entry = '0;
      req_bucket = '0;
      pool_reset();

      // extremes, error codes, all operations
      dir_tab[0]  = '{MODE_KILL,   7'd0,   8'd0,   1, '{7'd0, 7'd0, ST_UNUSED}};
      dir_tab[1]  = '{MODE_QUERY,  7'd127, 8'd255, 1, '{7'd0, 7'd0, ST_UNUSED}};
      dir_tab[2]  = '{MODE_MOVE,   7'd5,   8'd3,   1, '{7'd0, 7'd0, ST_UNUSED}};
      dir_tab[3]  = '{MODE_CREATE, 7'd127, 8'd0,   1, '{7'd0, 7'd0, ST_OK}};
      dir_tab[4]  = '{MODE_CREATE, 7'd0,   8'd255, 1, '{7'd1, 7'd0, ST_OK}};
      dir_tab[5]  = '{MODE_CREATE, 7'd0,   8'd0,   1, '{7'd2, 7'd0, ST_OK}};
      dir_tab[6]  = '{MODE_QUERY,  7'd2,   8'd0,   1, '{7'd0, 7'd0, ST_OK}};
      dir_tab[7]  = '{MODE_QUERY,  7'd0,   8'd0,   1, '{7'd0, 7'd2, ST_OK}};
      dir_tab[8]  = '{MODE_MOVE,   7'd0,   8'd0,   0, none};
      dir_tab[9]  = '{MODE_MOVE,   7'd2,   8'd255, 0, none};
      dir_tab[10] = '{MODE_KILL,   7'd1,   8'd0,   0, none};
      dir_tab[11] = '{MODE_QUERY,  7'd0,   8'd0,   0, none};
      dir_tab[12] = '{MODE_KILL,   7'd1,   8'd0,   1, '{7'd0, 7'd0, ST_UNUSED}};
      dir_tab[13] = '{MODE_CREATE, 7'd0,   8'd7,   1, '{7'd1, 7'd0, ST_OK}};
      dir_tab[14] = '{MODE_KILL,   7'd0,   8'd0,   0, none};
      dir_tab[15] = '{MODE_KILL,   7'd2,   8'd0,   0, none};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NDIR; i++)
         send(dir_tab[i].mode, dir_tab[i].entry, dir_tab[i].bucket,
              dir_tab[i].has_exp, dir_tab[i].res);

      // fill the pool past empty, then drain it
      for (int i = 0; i < ENTRIES + 2; i++)
         send(MODE_CREATE, 7'($urandom), 8'($urandom_range(0, 3)), 0, none);
      for (int i = 0; i < ENTRIES; i++)
         send(MODE_KILL, 7'(i), 8'($urandom), 0, none);

      // random mix biased toward live entries and few buckets
      n = 0;
      while (n < NRAND) begin
         if (n > NRAND - 150) quiet = 1;
         pick = $urandom_range(0, 9);
         mode_r = $urandom_range(0, 3);
         if (mode_r == MODE_CREATE && m_free >= ENTRIES && pick < 7) mode_r = MODE_KILL;
         if (pick < 8 && m_ahead < ENTRIES) begin
            // pick a live entry by walking a random distance down the active list
            int cur, hops;
            cur = m_ahead;
            hops = $urandom_range(0, 40);
            for (int h = 0; h < hops && m_alink[cur] < ENTRIES; h++) cur = m_alink[cur];
            send(2'(mode_r), 7'(cur),
                 (pick < 6) ? 8'($urandom_range(0, 5)) : 8'($urandom), 0, none);
         end else begin
            send(2'(mode_r), 7'($urandom), 8'($urandom), 0, none);
         end
         n++;
      end
      req_valid <= 1'b0;

      while (expected_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0)
         $display("tb_pooled_linked_list_manager_top passed");
      else
         $display("tb_pooled_linked_list_manager_top failed");
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/plm_pkg.sv
hw/rtl/plm_ram.sv
hw/rtl/plm_datapath.sv
hw/rtl/plm_ctrl.sv
hw/rtl/pooled_linked_list_manager_top.sv
test/tb_pooled_linked_list_manager_top.sv
